// File: sv/hand_command_frame_parser_defines.svh
// Assertion macros shared by the hand command frame parser RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef HAND_COMMAND_FRAME_PARSER_DEFINES_SVH
`define HAND_COMMAND_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCFP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcfp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HCFP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcfp: next-cycle check failed");

`endif

// File: sv/hcfp_pkg.sv
// Package for the hand command frame parser: widths, character codes,
// parse phases, state and result types and the keyword tables. No dependencies.
`timescale 1ns / 1ps

package hcfp_pkg;

  localparam int HEIGHT_BITS  = 32;
  localparam int HEIGHT_OUT_W = 32;

  // Keyword indexes into the token match flags.
  localparam logic [2:0] W_LEFT  = 3'd0;
  localparam logic [2:0] W_RIGHT = 3'd1;
  localparam logic [2:0] W_PUT   = 3'd2;
  localparam logic [2:0] W_GET   = 3'd3;
  localparam logic [2:0] W_NO    = 3'd4;
  localparam int         NUM_WORDS = 5;

  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] MODE_PUT  = 2'd1;
  localparam logic [1:0] MODE_GET  = 2'd2;
  localparam logic [1:0] MODE_NO   = 2'd3;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] POS_HDR_FIRST = 3'd1;
  localparam logic [2:0] POS_HDR_LAST  = 3'd5;
  localparam logic [2:0] POS_NOT_M     = 3'd6;
  localparam logic [2:0] POS_TOKEN     = 3'd7;
  localparam logic [2:0] LEN_MAX       = 3'd7;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_DIR,
    PH_SKIP1,
    PH_MODE,
    PH_SKIP2,
    PH_HEIGHT,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [2:0]             byte_pos;
    phase_t                 phase;
    logic                   skip;
    logic                   header_ok;
    logic [2:0]             token_len;
    logic [NUM_WORDS-1:0]   flags;
    logic [HEIGHT_BITS-1:0] acc;
    logic                   neg;
    logic                   stopped;
    logic                   close_seen;
    logic [1:0]             last_dir;
    logic [1:0]             last_mode;
  } hcfp_state_t;

  typedef struct packed {
    logic                           valid;
    logic [1:0]                     direction;
    logic [1:0]                     mode;
    logic signed [HEIGHT_OUT_W-1:0] height;
  } hcfp_result_t;

  localparam hcfp_state_t ST_RESET = '{
    byte_pos:   3'd0,
    phase:      PH_HEADER,
    skip:       1'b0,
    header_ok:  1'b1,
    token_len:  3'd0,
    flags:      '1,
    acc:        '0,
    neg:        1'b0,
    stopped:    1'b0,
    close_seen: 1'b0,
    last_dir:   2'd0,
    last_mode:  2'd0
  };

  // Expected header character at positions 1 to 5: "Hand,".
  function automatic logic [7:0] head_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd1:    ch = 8'h48;
      3'd2:    ch = 8'h61;
      3'd3:    ch = 8'h6E;
      3'd4:    ch = 8'h64;
      3'd5:    ch = CH_COMMA;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] word_len(input logic [2:0] w);
    logic [2:0] len;
    case (w)
      W_LEFT:  len = 3'd4;
      W_RIGHT: len = 3'd5;
      W_PUT:   len = 3'd3;
      W_GET:   len = 3'd3;
      W_NO:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Character of keyword w at position pos; zero past the end of the word.
  function automatic logic [7:0] word_char(input logic [2:0] w, input logic [2:0] pos);
    logic [39:0] txt;
    case (w)
      W_LEFT:  txt = 40'h4C_65_66_74_00;
      W_RIGHT: txt = 40'h52_69_67_68_74;
      W_PUT:   txt = 40'h50_75_74_00_00;
      W_GET:   txt = 40'h47_65_74_00_00;
      W_NO:    txt = 40'h4E_6F_00_00_00;
      default: txt = 40'h0;
    endcase
    case (pos)
      3'd0:    return txt[39:32];
      3'd1:    return txt[31:24];
      3'd2:    return txt[23:16];
      3'd3:    return txt[15:8];
      3'd4:    return txt[7:0];
      default: return 8'h00;
    endcase
  endfunction

endpackage

// File: sv/hcfp_step.sv
// Next-state and result logic of the frame parser for one character.
// Purely combinational; depends on hcfp_pkg.
`timescale 1ns / 1ps

module hcfp_step (
  input  hcfp_pkg::hcfp_state_t  st,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output hcfp_pkg::hcfp_state_t  st_nxt,
  output hcfp_pkg::hcfp_result_t res
);

  logic                             long_enough;
  logic [hcfp_pkg::HEIGHT_BITS-1:0] mag;
  logic [3:0]                       digit;
  logic                             is_digit;
  logic [1:0]                       dir_match;
  logic [1:0]                       mode_match;

  assign long_enough = (st.phase != hcfp_pkg::PH_HEADER) ||
                       (st.byte_pos >= hcfp_pkg::POS_HDR_LAST);
  assign is_digit    = (data_byte >= hcfp_pkg::CH_ZERO) && (data_byte <= hcfp_pkg::CH_NINE);
  assign digit       = 4'(data_byte - hcfp_pkg::CH_ZERO);
  // The accumulator never moves on the cycle that sets close_seen, so the
  // current value is the one to report.
  assign mag         = st.neg ? hcfp_pkg::HEIGHT_BITS'(-st.acc) : st.acc;

  always_comb begin
    dir_match = 2'd0;
    if (st.flags[hcfp_pkg::W_LEFT] && st.token_len == hcfp_pkg::word_len(hcfp_pkg::W_LEFT)) begin
      dir_match = hcfp_pkg::DIR_LEFT;
    end else if (st.flags[hcfp_pkg::W_RIGHT] &&
                 st.token_len == hcfp_pkg::word_len(hcfp_pkg::W_RIGHT)) begin
      dir_match = hcfp_pkg::DIR_RIGHT;
    end
    mode_match = 2'd0;
    if (st.flags[hcfp_pkg::W_PUT] && st.token_len == hcfp_pkg::word_len(hcfp_pkg::W_PUT)) begin
      mode_match = hcfp_pkg::MODE_PUT;
    end else if (st.flags[hcfp_pkg::W_GET] &&
                 st.token_len == hcfp_pkg::word_len(hcfp_pkg::W_GET)) begin
      mode_match = hcfp_pkg::MODE_GET;
    end else if (st.flags[hcfp_pkg::W_NO] &&
                 st.token_len == hcfp_pkg::word_len(hcfp_pkg::W_NO)) begin
      mode_match = hcfp_pkg::MODE_NO;
    end
  end

  always_comb begin
    st_nxt = st;
    case (st.phase)
      hcfp_pkg::PH_HEADER: begin
        if (st.byte_pos >= hcfp_pkg::POS_HDR_FIRST && st.byte_pos <= hcfp_pkg::POS_HDR_LAST &&
            data_byte != hcfp_pkg::head_char(st.byte_pos)) begin
          st_nxt.header_ok = 1'b0;
        end
        if (st.byte_pos == hcfp_pkg::POS_NOT_M && data_byte == hcfp_pkg::CH_M) begin
          st_nxt.header_ok = 1'b0;
        end
        if (st.byte_pos == hcfp_pkg::POS_TOKEN) begin
          st_nxt.phase     = hcfp_pkg::PH_DIR;
          st_nxt.token_len = 3'd0;
          st_nxt.flags     = '1;
          st_nxt.skip      = 1'b0;
        end else begin
          st_nxt.byte_pos = st.byte_pos + 3'd1;
        end
      end
      hcfp_pkg::PH_DIR, hcfp_pkg::PH_MODE: begin
        if (data_byte == hcfp_pkg::CH_COMMA) begin
          if (st.phase == hcfp_pkg::PH_DIR) begin
            if (dir_match != 2'd0 && st.header_ok) begin
              st_nxt.last_dir = dir_match;
            end
            st_nxt.phase = hcfp_pkg::PH_SKIP1;
          end else begin
            if (mode_match != 2'd0 && st.header_ok) begin
              st_nxt.last_mode = mode_match;
            end
            st_nxt.phase = hcfp_pkg::PH_SKIP2;
          end
          st_nxt.skip = 1'b0;
        end else begin
          for (int k = 0; k < hcfp_pkg::NUM_WORDS; k++) begin
            if (st.token_len >= hcfp_pkg::word_len(3'(k)) ||
                hcfp_pkg::word_char(3'(k), st.token_len) != data_byte) begin
              st_nxt.flags[k] = 1'b0;
            end
          end
          if (st.token_len != hcfp_pkg::LEN_MAX) begin
            st_nxt.token_len = st.token_len + 3'd1;
          end
        end
      end
      hcfp_pkg::PH_SKIP1, hcfp_pkg::PH_SKIP2: begin
        if (st.skip) begin
          st_nxt.phase     = (st.phase == hcfp_pkg::PH_SKIP1) ? hcfp_pkg::PH_MODE
                                                               : hcfp_pkg::PH_HEIGHT;
          st_nxt.token_len = 3'd0;
          st_nxt.flags     = '1;
          st_nxt.skip      = 1'b0;
        end else begin
          st_nxt.skip = 1'b1;
        end
      end
      hcfp_pkg::PH_HEIGHT: begin
        if (st.token_len == 3'd0 && data_byte == hcfp_pkg::CH_MINUS) begin
          st_nxt.neg = 1'b1;
        end else if (data_byte == hcfp_pkg::CH_CLOSE) begin
          st_nxt.close_seen = 1'b1;
          st_nxt.phase      = hcfp_pkg::PH_DONE;
        end else if (!st.stopped) begin
          if (is_digit) begin
            // acc * 10 + digit as two shifted terms, wrapping at the height width.
            st_nxt.acc = (st.acc << 3) + (st.acc << 1) +
                         hcfp_pkg::HEIGHT_BITS'(digit);
          end else begin
            st_nxt.stopped = 1'b1;
          end
        end
        if (st.token_len != hcfp_pkg::LEN_MAX) begin
          st_nxt.token_len = st.token_len + 3'd1;
        end
      end
      default: begin
      end
    endcase

    res.valid     = last_byte && st_nxt.header_ok && long_enough;
    res.direction = st_nxt.last_dir;
    res.mode      = st_nxt.last_mode;
    res.height    = st_nxt.close_seen ? hcfp_pkg::HEIGHT_OUT_W'(signed'(mag)) : '0;

    // The final character closes the message whether or not it was valid.
    if (last_byte) begin
      st_nxt           = hcfp_pkg::ST_RESET;
      st_nxt.last_dir  = res.direction;
      st_nxt.last_mode = res.mode;
    end
  end

endmodule

// File: sv/hand_command_frame_parser.sv
// Top level of the hand command frame parser: input register, parser state
// and result register around hcfp_step. Depends on hcfp_pkg and the defines header.
`timescale 1ns / 1ps
`include "hand_command_frame_parser_defines.svh"

// Feeds one character per item on the input channel, with in_last_byte set on the
// final character of a command such as "xHand,?xLeft,??Put,??-123)". One item is
// taken every clock cycle unless a held result waits on out_ready, and a result
// passes through the input register and then the result register after the final
// character was taken. The per-character state update (keyword match, times-ten
// accumulate) lies between those registers; the accumulate add is the longest path.
// A result appears only for the final character of a message with a good header;
// direction and mode keep their last matched values across messages, and height
// is zero unless a closing parenthesis was seen.
module hand_command_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_direction,
  output logic [1:0]  out_mode,
  output logic signed [hcfp_pkg::HEIGHT_OUT_W-1:0] out_height
);

  logic                   s1_valid_r;
  logic [7:0]             s1_data_r;
  logic                   s1_last_r;
  hcfp_pkg::hcfp_state_t  st_r;
  hcfp_pkg::hcfp_state_t  st_nxt;
  hcfp_pkg::hcfp_result_t res;
  logic                   out_valid_r;
  logic [1:0]             out_direction_r;
  logic [1:0]             out_mode_r;
  logic signed [hcfp_pkg::HEIGHT_OUT_W-1:0] out_height_r;
  logic                   advance;
  logic                   proc;

  hcfp_step u_step (
    .st        (st_r),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // The held item is processed whenever the result register can take its outcome.
  assign advance  = !out_valid_r || out_ready;
  assign proc     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= hcfp_pkg::ST_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
        s1_data_r  <= in_data_byte;
        s1_last_r  <= in_last_byte;
      end
      if (proc) begin
        st_r <= st_nxt;
      end
      if (advance) begin
        out_valid_r <= proc && res.valid;
      end
      if (proc && res.valid) begin
        out_direction_r <= res.direction;
        out_mode_r      <= res.mode;
        out_height_r    <= res.height;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_direction = out_direction_r;
  assign out_mode      = out_mode_r;
  assign out_height    = out_height_r;

  `HCFP_ASSERT_IMP(a_ready_when_out_free, !out_valid_r, in_ready)
  `HCFP_ASSERT_IMP(a_pos_past_header, st_r.phase != hcfp_pkg::PH_HEADER, st_r.byte_pos == hcfp_pkg::POS_TOKEN)
  `HCFP_ASSERT_IMP(a_close_only_done, st_r.close_seen, st_r.phase == hcfp_pkg::PH_DONE)
  `HCFP_ASSERT_IMP(a_dir_legal, out_valid_r, out_direction != 2'd3)
  `HCFP_ASSERT_NXT(a_clear_after_last, proc && s1_last_r, (st_r.phase == hcfp_pkg::PH_HEADER) && (st_r.byte_pos == 3'd0))

endmodule
